FILE: rtl/lome_pkg.sv
// Shared types, sizes and codes of the limit order matching engine.
`default_nettype none
package lome_pkg;

	localparam int MAX_ORDERS  = 1024;
	localparam int MAX_REPORTS = 64;
	localparam int SLOT_AW     = $clog2(MAX_ORDERS);
	localparam int RCNT_W      = $clog2(MAX_REPORTS + 1);

	localparam logic [1:0] OP_NEW    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;

	localparam logic [2:0] RK_NEW_ACK = 3'd0;
	localparam logic [2:0] RK_NEW_REJ = 3'd1;
	localparam logic [2:0] RK_PARTIAL = 3'd2;
	localparam logic [2:0] RK_FILL    = 3'd3;
	localparam logic [2:0] RK_CXL_ACK = 3'd4;
	localparam logic [2:0] RK_CXL_REJ = 3'd5;

	localparam logic [1:0] CLS_REJECT = 2'd0;
	localparam logic [1:0] CLS_NEW    = 2'd1;
	localparam logic [1:0] CLS_CANCEL = 2'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] client_id;
		logic [31:0] echo_exchange_id;
		logic [15:0] symbol_id;
		logic        side;
		logic        order_kind;
		logic [31:0] limit_price;
		logic [31:0] order_quantity;
		logic [63:0] send_time;
	} request_t;

	typedef struct packed {
		logic [31:0] report_client_id;
		logic [31:0] report_exchange_id;
		logic [2:0]  report_kind;
		logic [15:0] report_symbol;
		logic        report_side;
		logic [31:0] fill_price;
		logic [31:0] fill_qty;
		logic [31:0] cum_qty;
		logic [31:0] open_qty;
		logic [63:0] report_time;
		logic        last_report;
	} report_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] client_id;
		logic [31:0] exchange_id;
		logic [15:0] symbol;
		logic        side;
		logic [31:0] price;
		logic [31:0] filled;
		logic [31:0] remaining;
		logic [31:0] arrival_seq;
	} slot_t;

	typedef struct packed {
		request_t   req;
		logic [1:0] cls;
	} item_t;

endpackage
`default_nettype wire

FILE: rtl/lome_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lome_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/lome_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module lome_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire lome_pkg::request_t  request,
	input  wire logic                clearing,
	input  wire logic                pop,
	output logic                     busy,
	output logic                     q_valid,
	output lome_pkg::item_t          q_item
);
	import lome_pkg::*;

	item_t      ent_q [2];
	logic       head_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       tail;
	item_t      in_item;
	logic       static_ok;

	always_comb begin
		static_ok = (request.opcode == OP_NEW) && (request.client_id != '0)
			&& (request.symbol_id != '0) && !request.order_kind
			&& (request.limit_price != '0) && (request.order_quantity != '0);
		in_item.req = request;
		if (request.opcode == OP_CANCEL)
			in_item.cls = CLS_CANCEL;
		else if (static_ok)
			in_item.cls = CLS_NEW;
		else
			in_item.cls = CLS_REJECT;
	end

	assign busy    = (cnt_q == 2'd2) || clearing;
	assign push    = start && !busy;
	assign tail    = head_q ^ cnt_q[0];
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (pop && q_valid)
				head_q <= ~head_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[tail] <= in_item;
	end
endmodule
`default_nettype wire

FILE: rtl/lome_back.sv
// Back end: scans the order store, matches, updates the book and emits reports.
`default_nettype none
module lome_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire lome_pkg::item_t     q_item,
	output logic                     pop,
	output logic                     clearing,
	output logic                     result_valid,
	output lome_pkg::report_t        result
);
	import lome_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_FILL_A = 3'd4;
	localparam logic [2:0] ST_FILL_B = 3'd5;
	localparam logic [2:0] ST_REST   = 3'd6;
	localparam logic [2:0] ST_FINISH = 3'd7;

	localparam logic [1:0] SC_CANCEL = 2'd0;
	localparam logic [1:0] SC_DUP    = 2'd1;
	localparam logic [1:0] SC_BEST   = 2'd2;

	localparam logic [SLOT_AW-1:0] LAST_ADDR = SLOT_AW'(MAX_ORDERS - 1);

	logic [2:0]         state_q;
	logic [1:0]         mode_q;
	logic [SLOT_AW-1:0] scan_addr_q;
	logic               issue_q;
	logic               rv_s1;
	logic [SLOT_AW-1:0] addr_s1;
	logic               found_q;
	logic [SLOT_AW-1:0] found_addr_q;
	slot_t              found_e_q;
	logic [31:0]        bage_q;
	logic               free_found_q;
	logic [SLOT_AW-1:0] free_addr_q;
	request_t           req_q;
	logic [31:0]        next_q;
	logic [31:0]        arrival_q;
	logic [31:0]        xid_q;
	logic [31:0]        rem_q;
	logic [31:0]        cum_q;
	logic [31:0]        fq_q;
	logic [31:0]        fprice_q;
	logic [RCNT_W-1:0]  rcnt_q;
	logic               pend_v_q;
	report_t            pend_r_q;
	logic               out_v_q;
	report_t            out_r_q;

	logic               we;
	logic [SLOT_AW-1:0] waddr;
	slot_t              wdata;
	slot_t              rd_e;
	logic [$bits(slot_t)-1:0] rdata_raw;

	logic               emit_v;
	report_t            emit_r;
	logic               emit_go;
	logic               start_scan;
	logic [1:0]         start_mode;

	logic [31:0]        fq;
	logic [31:0]        slot_rem_new;
	logic [31:0]        age;
	logic               cand;
	logic               better;
	logic               id_match;
	report_t            pend_last;

	lome_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_ORDERS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (scan_addr_q),
		.rdata (rdata_raw)
	);
	assign rd_e = slot_t'(rdata_raw);

	// slot comparison during a scan
	always_comb begin
		id_match = rd_e.valid && (rd_e.client_id == req_q.client_id);
		age      = arrival_q - rd_e.arrival_seq;
		cand     = rd_e.valid && (rd_e.side != req_q.side)
			&& (req_q.side ? (rd_e.price >= req_q.limit_price)
			               : (rd_e.price <= req_q.limit_price));
		if (!found_q)
			better = 1'b1;
		else if (rd_e.price != found_e_q.price)
			better = req_q.side ? (rd_e.price > found_e_q.price)
			                    : (rd_e.price < found_e_q.price);
		else
			better = age > bage_q;
		fq = (rem_q < found_e_q.remaining) ? rem_q : found_e_q.remaining;
		slot_rem_new = found_e_q.remaining - fq;
	end

	always_comb begin
		pop        = 1'b0;
		emit_v     = 1'b0;
		emit_r     = '0;
		we         = 1'b0;
		waddr      = found_addr_q;
		wdata      = found_e_q;
		start_scan = 1'b0;
		start_mode = SC_CANCEL;
		emit_r.report_time = req_q.send_time;
		unique case (state_q)
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = scan_addr_q;
				wdata = '0;
			end
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					unique case (q_item.cls)
						CLS_CANCEL: begin
							start_scan = 1'b1;
							start_mode = SC_CANCEL;
						end
						CLS_NEW: begin
							start_scan = 1'b1;
							start_mode = SC_DUP;
						end
						default: begin
							emit_v = 1'b1;
							emit_r.report_client_id = q_item.req.client_id;
							emit_r.report_kind      = RK_NEW_REJ;
							emit_r.report_symbol    = q_item.req.symbol_id;
							emit_r.report_side      = q_item.req.side;
							emit_r.report_time      = q_item.req.send_time;
						end
					endcase
				end
			end
			ST_DECIDE: begin
				emit_r.report_client_id = req_q.client_id;
				emit_r.report_symbol    = req_q.symbol_id;
				emit_r.report_side      = req_q.side;
				unique case (mode_q)
					SC_CANCEL: begin
						emit_v = 1'b1;
						if (found_q) begin
							emit_r.report_client_id   = found_e_q.client_id;
							emit_r.report_exchange_id = found_e_q.exchange_id;
							emit_r.report_kind        = RK_CXL_ACK;
							emit_r.report_symbol      = found_e_q.symbol;
							emit_r.report_side        = found_e_q.side;
							emit_r.cum_qty            = found_e_q.filled;
							emit_r.open_qty           = found_e_q.remaining;
							we          = 1'b1;
							wdata.valid = 1'b0;
						end else begin
							emit_r.report_exchange_id = req_q.echo_exchange_id;
							emit_r.report_kind        = RK_CXL_REJ;
						end
					end
					SC_DUP: begin
						emit_v = 1'b1;
						if (found_q || !free_found_q) begin
							emit_r.report_kind = RK_NEW_REJ;
						end else begin
							emit_r.report_exchange_id = next_q;
							emit_r.report_kind        = RK_NEW_ACK;
							emit_r.open_qty           = req_q.order_quantity;
							start_scan = 1'b1;
							start_mode = SC_BEST;
						end
					end
					default: ;
				endcase
			end
			ST_FILL_A: begin
				emit_v = 1'b1;
				emit_r.report_client_id   = found_e_q.client_id;
				emit_r.report_exchange_id = found_e_q.exchange_id;
				emit_r.report_kind        = (slot_rem_new == '0) ? RK_FILL : RK_PARTIAL;
				emit_r.report_symbol      = found_e_q.symbol;
				emit_r.report_side        = found_e_q.side;
				emit_r.fill_price         = found_e_q.price;
				emit_r.fill_qty           = fq;
				emit_r.cum_qty            = found_e_q.filled + fq;
				emit_r.open_qty           = slot_rem_new;
				we              = 1'b1;
				wdata.filled    = found_e_q.filled + fq;
				wdata.remaining = slot_rem_new;
				wdata.valid     = (slot_rem_new != '0);
			end
			ST_FILL_B: begin
				emit_v = 1'b1;
				emit_r.report_client_id   = req_q.client_id;
				emit_r.report_exchange_id = xid_q;
				emit_r.report_kind        = (rem_q == '0) ? RK_FILL : RK_PARTIAL;
				emit_r.report_symbol      = req_q.symbol_id;
				emit_r.report_side        = req_q.side;
				emit_r.fill_price         = fprice_q;
				emit_r.fill_qty           = fq_q;
				emit_r.cum_qty            = cum_q;
				emit_r.open_qty           = rem_q;
				if (rem_q != '0) begin
					start_scan = 1'b1;
					start_mode = SC_BEST;
				end
			end
			ST_REST: begin
				we    = 1'b1;
				waddr = free_addr_q;
				wdata.valid       = 1'b1;
				wdata.client_id   = req_q.client_id;
				wdata.exchange_id = xid_q;
				wdata.symbol      = req_q.symbol_id;
				wdata.side        = req_q.side;
				wdata.price       = req_q.limit_price;
				wdata.filled      = cum_q;
				wdata.remaining   = rem_q;
				wdata.arrival_seq = arrival_q;
			end
			default: ;
		endcase
	end

	assign emit_go   = emit_v && (rcnt_q < RCNT_W'(MAX_REPORTS));
	assign clearing  = (state_q == ST_CLEAR);
	assign result_valid = out_v_q;
	assign result    = out_r_q;

	always_comb begin
		pend_last = pend_r_q;
		pend_last.last_report = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			mode_q       <= SC_CANCEL;
			scan_addr_q  <= '0;
			issue_q      <= 1'b0;
			rv_s1        <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			next_q       <= 32'd1;
			arrival_q    <= '0;
			rcnt_q       <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			out_v_q <= 1'b0;
			rv_s1   <= issue_q && (state_q == ST_SCAN);
			if (emit_go) begin
				pend_v_q <= 1'b1;
				rcnt_q   <= rcnt_q + 1'b1;
				out_v_q  <= pend_v_q;
			end
			if (start_scan) begin
				scan_addr_q  <= '0;
				issue_q      <= 1'b1;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
				mode_q       <= start_mode;
				state_q      <= ST_SCAN;
			end else begin
				unique case (state_q)
					ST_CLEAR: begin
						scan_addr_q <= scan_addr_q + 1'b1;
						if (scan_addr_q == LAST_ADDR)
							state_q <= ST_IDLE;
					end
					ST_IDLE: begin
						if (q_valid)
							state_q <= ST_FINISH;
					end
					ST_SCAN: begin
						if (issue_q) begin
							scan_addr_q <= scan_addr_q + 1'b1;
							if (scan_addr_q == LAST_ADDR)
								issue_q <= 1'b0;
						end
						if (rv_s1) begin
							if (!rd_e.valid && !free_found_q)
								free_found_q <= 1'b1;
							if (mode_q == SC_BEST) begin
								if (cand && better)
									found_q <= 1'b1;
							end else if (id_match && !found_q) begin
								found_q <= 1'b1;
							end
							if (addr_s1 == LAST_ADDR)
								state_q <= ST_DECIDE;
						end
					end
					ST_DECIDE: begin
						if (mode_q == SC_BEST) begin
							if (found_q)
								state_q <= ST_FILL_A;
							else if ((rem_q != '0) && free_found_q)
								state_q <= ST_REST;
							else
								state_q <= ST_FINISH;
						end else begin
							state_q <= ST_FINISH;
						end
					end
					ST_FILL_A: state_q <= ST_FILL_B;
					ST_FILL_B: state_q <= ST_FINISH;
					ST_REST: begin
						arrival_q <= arrival_q + 1'b1;
						state_q   <= ST_FINISH;
					end
					ST_FINISH: begin
						// flush the held report as the last one of this request
						out_v_q  <= pend_v_q;
						pend_v_q <= 1'b0;
						rcnt_q   <= '0;
						state_q  <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
			if (state_q == ST_DECIDE && mode_q == SC_DUP && start_scan)
				next_q <= next_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= scan_addr_q;
		if (emit_go) begin
			pend_r_q <= emit_r;
			out_r_q  <= pend_r_q;
		end
		if (state_q == ST_FINISH)
			out_r_q <= pend_last;
		if (pop && q_valid)
			req_q <= q_item.req;
		if (state_q == ST_SCAN && rv_s1) begin
			if (!rd_e.valid && !free_found_q)
				free_addr_q <= addr_s1;
			if ((mode_q == SC_BEST) ? (cand && better) : (id_match && !found_q)) begin
				found_addr_q <= addr_s1;
				found_e_q    <= rd_e;
				bage_q       <= age;
			end
		end
		if (state_q == ST_DECIDE && mode_q == SC_DUP) begin
			xid_q <= next_q;
			rem_q <= req_q.order_quantity;
			cum_q <= '0;
		end
		if (state_q == ST_FILL_A) begin
			rem_q    <= rem_q - fq;
			cum_q    <= cum_q + fq;
			fq_q     <= fq;
			fprice_q <= found_e_q.price;
		end
	end

	a_no_report_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !emit_v)
		else $error("report produced during store clear");
	a_cap_held: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCNT_W'(MAX_REPORTS))
		else $error("report count past cap");
	a_fill_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL_A) |-> found_q)
		else $error("fill without a matched slot");
	a_finish_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (out_v_q && !pend_v_q))
		else $error("request ended without a last report");
endmodule
`default_nettype wire

FILE: rtl/limit_order_matching_engine.sv
// Top level of the limit order matching engine: front end, back end and order store.
// Sequence: a reject is reported without any scan; each scan reads all MAX_ORDERS slots of
// the store before its decision; a cancel or a new order needs one scan, an acked order one
// more scan per fill and one before resting, and each fill adds the FILL_A and FILL_B states.
// Throughput: one request at a time in the back end, two more may wait in the front queue.
// Reset: the order store is cleared one slot per cycle, all MAX_ORDERS slots; busy stays
// high meanwhile. The receiver cannot stall; each report is shown for one cycle.
`default_nettype none
module limit_order_matching_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire lome_pkg::request_t  request,
	output logic                     busy,
	output logic                     result_valid,
	output lome_pkg::report_t        result
);
	import lome_pkg::*;

	logic  pop;
	logic  clearing;
	logic  q_valid;
	item_t q_item;

	lome_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.clearing (clearing),
		.pop      (pop),
		.busy     (busy),
		.q_valid  (q_valid),
		.q_item   (q_item)
	);

	lome_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result       (result)
	);
endmodule
`default_nettype wire
